/* hw/rtl/xcr_pkg.sv */
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Shared types, protocol byte codes, command and status codes.
// ----------------------------------------------------------------------------
package xcr_pkg;

    // Block geometry: 128 data bytes, framed by SOH, number, complement, sum.
    localparam int BLOCK_BYTES = 128;
    localparam int FRAME_BYTES = BLOCK_BYTES + 4;
    localparam int WORDS       = BLOCK_BYTES / 4;
    localparam int WORD_IDX_W  = $clog2(WORDS);

    // Protocol bytes.
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_CAN = 8'h18;

    // Input commands.
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_BYTE  = 3'd1;
    localparam logic [2:0] CMD_TMO   = 3'd2;
    localparam logic [2:0] CMD_ERR   = 3'd3;
    localparam logic [2:0] CMD_FLASH = 3'd4;

    // Session status codes.
    localparam logic [2:0] STAT_BUSY    = 3'd0;
    localparam logic [2:0] STAT_OK      = 3'd1;
    localparam logic [2:0] STAT_TIMEOUT = 3'd2;
    localparam logic [2:0] STAT_COMMS   = 3'd3;
    localparam logic [2:0] STAT_FLASH   = 3'd4;

    // Configuration register indexes.
    localparam int         CFG_IDX_W         = 1;
    localparam logic [0:0] CFG_FLASH_BASE    = 1'd0;
    localparam logic [0:0] CFG_RETRY_LIMIT   = 1'd1;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_byte;
        logic       flash_ok;
    } xcr_in_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        flash_valid;
        logic [31:0] flash_address;
        logic [31:0] flash_word;
        logic [2:0]  session_status;
        logic        last;
    } xcr_out_t;

endpackage

/* hw/rtl/xcr_block_ram.sv */
// ----------------------------------------------------------------------------
// XMODEM receiver block store
// One-write, one-read word memory holding the data of the current frame.
// ----------------------------------------------------------------------------
module xcr_block_ram
    import xcr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [WORD_IDX_W-1:0] wr_addr,
    input  logic [31:0]           wr_data,
    input  logic                  rd_en,
    input  logic [WORD_IDX_W-1:0] rd_addr,
    output logic [31:0]           rd_data
);

    logic [31:0] mem [WORDS];
    logic [31:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds between reads.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/xmodem_checksum_receiver.sv */
// ----------------------------------------------------------------------------
// XMODEM checksum receiver
// Session control, frame checking and block handoff for 128-byte blocks.
// ----------------------------------------------------------------------------
// Every command is taken and gives its reply, if any, in the output register
// the cycle after. The final byte of a good new block starts a handoff that
// walks the 32 stored words through the single read port of the block
// memory, each word read and then sent, so that command holds the input until
// the last word is sent; a failed programming result gives a second reply
// after its first. A command is taken only when the output register is free
// or being emptied.
module xmodem_checksum_receiver
    import xcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  xcr_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output xcr_out_t             m_data
);

    // Session phase.
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_WAIT  = 5'b00010,
        PH_FRAME = 5'b00100,
        PH_FLASH = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    // Sequencer for multi-result commands.
    typedef enum logic [3:0] {
        SQ_IDLE  = 4'b0001,
        SQ_FETCH = 4'b0010,
        SQ_SEND  = 4'b0100,
        SQ_CAN   = 4'b1000
    } seq_t;

    logic [31:0]           base_reg;
    logic [7:0]            retry_limit_reg;
    phase_t                phase_reg, phase_next;
    seq_t                  seq_reg, seq_next;
    logic                  started_reg, started_next;
    logic [7:0]            retries_reg, retries_next;
    logic [7:0]            expected_reg, expected_next;
    logic [7:0]            left_reg, left_next;
    logic [7:0]            header_reg, header_next;
    logic [7:0]            blknum_reg, blknum_next;
    logic [7:0]            compl_reg, compl_next;
    logic [7:0]            sum_reg, sum_next;
    logic [23:0]           acc_reg, acc_next;
    logic [31:0]           waddr_reg, waddr_next;
    logic [31:0]           emit_addr_reg, emit_addr_next;
    logic [WORD_IDX_W-1:0] idx_reg, idx_next;
    logic                  m_valid_reg;
    xcr_out_t              m_data_reg;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    xcr_out_t              out_pay;
    logic                  ram_wr_en;
    logic [WORD_IDX_W-1:0] ram_wr_addr;
    logic [31:0]           ram_wr_data;
    logic                  ram_rd_en;
    logic [31:0]           ram_rd_data;
    logic [7:0]            data_pos;
    logic [7:0]            prev_block;
    logic [8:0]            num_sum;
    logic                  frame_good;

    // Builds a reply-only result.
    function automatic xcr_out_t reply(input logic tx_en, input logic [7:0] tx,
                                       input logic [2:0] st, input logic lst);
        xcr_out_t r;
        r                = '0;
        r.tx_valid       = tx_en;
        r.tx_byte        = tx;
        r.session_status = st;
        r.last           = lst;
        return r;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (seq_reg == SQ_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // Frame check terms.
    assign data_pos   = 8'(BLOCK_BYTES + 1) - left_reg;
    assign prev_block = expected_reg - 8'd1;
    assign num_sum    = {1'b0, blknum_reg} + {1'b0, compl_reg};
    assign frame_good = (header_reg == BYTE_SOH) &&
                        ((blknum_reg == expected_reg) || (blknum_reg == prev_block)) &&
                        (num_sum == 9'd255) && (sum_reg == s_data.rx_byte);

    // Block memory.
    xcr_block_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Command handling and handoff sequencer.
    always_comb begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        started_next   = started_reg;
        retries_next   = retries_reg;
        expected_next  = expected_reg;
        left_next      = left_reg;
        header_next    = header_reg;
        blknum_next    = blknum_reg;
        compl_next     = compl_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        waddr_next     = waddr_reg;
        emit_addr_next = emit_addr_reg;
        idx_next       = idx_reg;
        out_load       = 1'b0;
        out_pay        = '0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = data_pos[WORD_IDX_W+1:2];
        ram_wr_data    = {s_data.rx_byte, acc_reg};
        ram_rd_en      = 1'b0;

        case (seq_reg)
            SQ_IDLE: begin
                if (accept) begin
                    case (s_data.command)
                        CMD_START: begin
                            expected_next = 8'd1;
                            started_next  = 1'b0;
                            waddr_next    = base_reg;
                            left_next     = '0;
                            sum_next      = '0;
                            phase_next    = PH_WAIT;
                            retries_next  = retry_limit_reg;
                            out_load      = 1'b1;
                            out_pay       = reply(1'b1, BYTE_NAK, STAT_BUSY, 1'b1);
                        end
                        CMD_BYTE: begin
                            if (phase_reg == PH_WAIT) begin
                                started_next = 1'b1;
                                if (s_data.rx_byte == BYTE_EOT) begin
                                    phase_next = PH_DONE;
                                    out_load   = 1'b1;
                                    out_pay    = reply(1'b1, BYTE_ACK, STAT_OK, 1'b1);
                                end else begin
                                    header_next = s_data.rx_byte;
                                    sum_next    = '0;
                                    left_next   = 8'(FRAME_BYTES - 1);
                                    phase_next  = PH_FRAME;
                                end
                            end else if (phase_reg == PH_FRAME) begin
                                // Capture the header fields or one data byte.
                                if (left_reg == 8'(FRAME_BYTES - 1)) begin
                                    blknum_next = s_data.rx_byte;
                                end else if (left_reg == 8'(FRAME_BYTES - 2)) begin
                                    compl_next = s_data.rx_byte;
                                end else if (left_reg >= 8'd2) begin
                                    sum_next = sum_reg + s_data.rx_byte;
                                    case (data_pos[1:0])
                                        2'd0: acc_next = {16'd0, s_data.rx_byte};
                                        2'd1: acc_next = {8'd0, s_data.rx_byte,
                                                          acc_reg[7:0]};
                                        2'd2: acc_next = {s_data.rx_byte,
                                                          acc_reg[15:0]};
                                        default: ram_wr_en = 1'b1;
                                    endcase
                                end
                                // Count down, or judge the frame on its sum byte.
                                if (left_reg > 8'd1) begin
                                    left_next = left_reg - 8'd1;
                                end else begin
                                    left_next = '0;
                                    if (!frame_good) begin
                                        phase_next   = PH_WAIT;
                                        retries_next = retry_limit_reg;
                                        out_load     = 1'b1;
                                        out_pay      = reply(1'b1, BYTE_NAK,
                                                             STAT_BUSY, 1'b1);
                                    end else if (blknum_reg == expected_reg) begin
                                        phase_next     = PH_FLASH;
                                        seq_next       = SQ_FETCH;
                                        idx_next       = '0;
                                        emit_addr_next = waddr_reg;
                                    end else begin
                                        phase_next   = PH_WAIT;
                                        retries_next = retry_limit_reg;
                                        out_load     = 1'b1;
                                        out_pay      = reply(1'b1, BYTE_ACK,
                                                             STAT_BUSY, 1'b1);
                                    end
                                end
                            end
                        end
                        CMD_TMO: begin
                            if (phase_reg == PH_WAIT) begin
                                if (retries_reg <= 8'd1) begin
                                    retries_next = '0;
                                    phase_next   = PH_DONE;
                                    out_load     = 1'b1;
                                    out_pay      = reply(1'b0, 8'd0, STAT_TIMEOUT, 1'b1);
                                end else begin
                                    retries_next = retries_reg - 8'd1;
                                    if (!started_reg) begin
                                        out_load = 1'b1;
                                        out_pay  = reply(1'b1, BYTE_NAK, STAT_BUSY, 1'b1);
                                    end
                                end
                            end else if (phase_reg == PH_FRAME) begin
                                left_next    = '0;
                                phase_next   = PH_WAIT;
                                retries_next = retry_limit_reg;
                                out_load     = 1'b1;
                                out_pay      = reply(1'b1, BYTE_NAK, STAT_BUSY, 1'b1);
                            end
                        end
                        CMD_ERR: begin
                            if (phase_reg == PH_WAIT) begin
                                started_next = 1'b1;
                                phase_next   = PH_DONE;
                                out_load     = 1'b1;
                                out_pay      = reply(1'b0, 8'd0, STAT_COMMS, 1'b1);
                            end else if (phase_reg == PH_FRAME) begin
                                left_next    = '0;
                                phase_next   = PH_WAIT;
                                retries_next = retry_limit_reg;
                                out_load     = 1'b1;
                                out_pay      = reply(1'b1, BYTE_NAK, STAT_BUSY, 1'b1);
                            end
                        end
                        CMD_FLASH: begin
                            if (phase_reg == PH_FLASH) begin
                                if (s_data.flash_ok) begin
                                    waddr_next    = waddr_reg + 32'(BLOCK_BYTES);
                                    expected_next = expected_reg + 8'd1;
                                    phase_next    = PH_WAIT;
                                    retries_next  = retry_limit_reg;
                                    out_load      = 1'b1;
                                    out_pay       = reply(1'b1, BYTE_ACK, STAT_BUSY, 1'b1);
                                end else begin
                                    phase_next = PH_DONE;
                                    seq_next   = SQ_CAN;
                                    out_load   = 1'b1;
                                    out_pay    = reply(1'b1, BYTE_NAK, STAT_FLASH, 1'b0);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            SQ_FETCH: begin
                ram_rd_en = 1'b1;
                seq_next  = SQ_SEND;
            end
            SQ_SEND: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    out_pay.flash_valid   = 1'b1;
                    out_pay.flash_address = emit_addr_reg;
                    out_pay.flash_word    = ram_rd_data;
                    out_pay.last          = (idx_reg == WORD_IDX_W'(WORDS - 1));
                    if (idx_reg == WORD_IDX_W'(WORDS - 1)) begin
                        seq_next = SQ_IDLE;
                    end else begin
                        idx_next       = idx_reg + 1'b1;
                        emit_addr_next = emit_addr_reg + 32'd4;
                        seq_next       = SQ_FETCH;
                    end
                end
            end
            SQ_CAN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_pay  = reply(1'b1, BYTE_CAN, STAT_FLASH, 1'b1);
                    seq_next = SQ_IDLE;
                end
            end
            default: begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg        <= '0;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FLASH_BASE:  base_reg        <= cfg_wr_data;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Session and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            seq_reg       <= SQ_IDLE;
            started_reg   <= 1'b0;
            retries_reg   <= '0;
            expected_reg  <= 8'd1;
            left_reg      <= '0;
            header_reg    <= '0;
            blknum_reg    <= '0;
            compl_reg     <= '0;
            sum_reg       <= '0;
            waddr_reg     <= '0;
            idx_reg       <= '0;
        end else begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            started_reg   <= started_next;
            retries_reg   <= retries_next;
            expected_reg  <= expected_next;
            left_reg      <= left_next;
            header_reg    <= header_next;
            blknum_reg    <= blknum_next;
            compl_reg     <= compl_next;
            sum_reg       <= sum_next;
            waddr_reg     <= waddr_next;
            idx_reg       <= idx_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        emit_addr_reg <= emit_addr_next;
    end

    // Output register: loads a new result, or empties on a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_pay;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
